// File: rtl/uart_bit_clock_recovery_unit_macros.svh
// Assertion macros used by the port-level checker of the bit-clock recovery unit.
// Each macro takes a label, the clock, a disable term and the two property sides.
`ifndef UART_BIT_CLOCK_RECOVERY_UNIT_MACROS_SVH
`define UART_BIT_CLOCK_RECOVERY_UNIT_MACROS_SVH

// Same-cycle implication
`define UBCR_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("ubcr checker: same-cycle property failed");

// Next-cycle implication
`define UBCR_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("ubcr checker: next-cycle property failed");

`endif

// File: rtl/ubcr_pkg.sv
// Shared types and constants of the UART bit-clock recovery unit.
// No dependencies; used by the queue, the sample engine and the top level.
`default_nettype none

package ubcr_pkg;

  // Bits in one UART frame (start, data, stop)
  localparam int BITS_PER_FRAME = 10;
  // Bit counter width; it also holds BITS_PER_FRAME, which means idle
  localparam int IDX_W          = $clog2(BITS_PER_FRAME + 1);

  localparam int EDGE_W   = 48;
  localparam int TIME_W   = 49;
  localparam int PERIOD_W = 32;

  // Nominal bit period at 115200 baud, in ps
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd8680555;

  // One queued edge
  typedef struct packed {
    logic [EDGE_W-1:0] edge_time;
    logic              new_capture;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/ubcr_queue.sv
// Front end: two-entry queue that takes edge items and hands them to the engine.
// Depends on ubcr_pkg for the item type.
`default_nettype none

module ubcr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ubcr_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_ready,
  output ubcr_pkg::item_t    q_item
);

  ubcr_pkg::item_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_item;
  end

endmodule

`default_nettype wire

// File: rtl/ubcr_engine.sv
// Back end: frame state, bit-centre stepping and the registered sample output.
// Depends on ubcr_pkg; fed by ubcr_queue.
`default_nettype none

module ubcr_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ubcr_pkg::PERIOD_W-1:0] cfg_data,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire ubcr_pkg::item_t               q_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ubcr_pkg::TIME_W-1:0]        sample_time,
  output logic                               sample_level,
  output logic                               last_of_run
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [ubcr_pkg::IDX_W-1:0] IDX_IDLE =
    ubcr_pkg::IDX_W'(ubcr_pkg::BITS_PER_FRAME);
  localparam logic [ubcr_pkg::IDX_W-1:0] IDX_LAST =
    ubcr_pkg::IDX_W'(ubcr_pkg::BITS_PER_FRAME - 1);

  state_t                          state, state_next;
  logic [ubcr_pkg::PERIOD_W-1:0]   period;
  logic [ubcr_pkg::EDGE_W-1:0]     edge_hold, edge_hold_next;
  logic [ubcr_pkg::TIME_W-1:0]     center, center_next;
  logic [ubcr_pkg::IDX_W-1:0]      index, index_next;
  logic                            level, level_next;
  logic                            out_valid_next;
  logic                            load_out;
  logic                            out_free;
  logic                            pop;
  logic [ubcr_pkg::TIME_W:0]       window;
  logic                            consumed;
  logic                            last_bit;
  logic [ubcr_pkg::TIME_W-1:0]     start_q;
  logic [ubcr_pkg::TIME_W-1:0]     start_hold;

  assign q_ready  = (state == ST_IDLE);
  assign pop      = q_valid && q_ready;
  assign out_free = !out_valid || out_ready;

  // Acceptance window of the current bit and the frame-start centres
  assign window   = {1'b0, center} + {20'd0, period[ubcr_pkg::PERIOD_W-1:2]};
  assign consumed = ({2'b00, edge_hold} < window);
  assign last_bit = (index == IDX_LAST);
  assign start_q    = {1'b0, q_item.edge_time} + {18'd0, period[ubcr_pkg::PERIOD_W-1:1]};
  assign start_hold = {1'b0, edge_hold} + {18'd0, period[ubcr_pkg::PERIOD_W-1:1]};

  // Next-state logic
  always_comb begin
    state_next     = state;
    edge_hold_next = edge_hold;
    center_next    = center;
    index_next     = index;
    level_next     = level;
    out_valid_next = out_valid && !out_ready;
    load_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          edge_hold_next = q_item.edge_time;
          if (q_item.new_capture || (index == IDX_IDLE)) begin
            // Edge while idle (or after a capture restart): open a frame
            center_next = start_q;
            index_next  = '0;
            if (q_item.new_capture) level_next = 1'b0;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          level_next     = ~level;
          center_next    = center + {17'd0, period};
          index_next     = index + 1'b1;
          if (consumed) begin
            state_next = ST_IDLE;
          end else if (last_bit) begin
            // Frame done with the edge unused: it opens the next frame
            center_next = start_hold;
            index_next  = '0;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      period    <= ubcr_pkg::PERIOD_RESET;
      center    <= '0;
      index     <= IDX_IDLE;
      level     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      center    <= center_next;
      index     <= index_next;
      level     <= level_next;
      out_valid <= out_valid_next;
      if (cfg_we) period <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    edge_hold <= edge_hold_next;
    if (load_out) begin
      sample_time  <= center;
      sample_level <= level;
      last_of_run  <= consumed || last_bit;
    end
  end

endmodule

`default_nettype wire

// File: rtl/uart_bit_clock_recovery_unit.sv
// UART bit-clock recovery: edge timestamps in, recovered bit-centre samples out.
// Flow: an accepted item is registered in the queue, then popped by the engine,
// which registers each of its samples (0 to 10) on the output and takes no new
// item until done; it emits one bit centre per cycle unless out_ready stalls it.
// Reset (rst, synchronous): queue empty, frame idle, level low, period 8680555 ps.
// Depends on ubcr_pkg, ubcr_queue and ubcr_engine.
`default_nettype none

module uart_bit_clock_recovery_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ubcr_pkg::PERIOD_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ubcr_pkg::EDGE_W-1:0]   edge_time,
  input  wire logic                          new_capture,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ubcr_pkg::TIME_W-1:0]        sample_time,
  output logic                               sample_level,
  output logic                               last_of_run
);

  ubcr_pkg::item_t in_item;
  ubcr_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  assign in_item.edge_time   = edge_time;
  assign in_item.new_capture = new_capture;

  // Front: edge queue
  ubcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back: sample engine
  ubcr_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_time  (sample_time),
    .sample_level (sample_level),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/ubcr_checker.sv
// Port-level checker for the UART bit-clock recovery unit, bound to the top level.
// Depends on ubcr_pkg and uart_bit_clock_recovery_unit_macros.svh.
`default_nettype none
`include "uart_bit_clock_recovery_unit_macros.svh"

module ubcr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cfg_we,
  input wire logic [ubcr_pkg::PERIOD_W-1:0] cfg_data,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [ubcr_pkg::EDGE_W-1:0]   edge_time,
  input wire logic                          new_capture,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ubcr_pkg::TIME_W-1:0]   sample_time,
  input wire logic                          sample_level,
  input wire logic                          last_of_run
);

  logic                          mid_run;
  logic                          prev_level;
  logic [ubcr_pkg::TIME_W-1:0]   prev_time;
  logic [ubcr_pkg::PERIOD_W-1:0] period;
  logic                          out_take;

  assign out_take = out_valid && out_ready;

  // Track the previous sample of a run and the configured period
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_run <= 1'b0;
      period  <= ubcr_pkg::PERIOD_RESET;
    end else begin
      if (out_take) mid_run <= !last_of_run;
      if (cfg_we)   period  <= cfg_data;
    end
    if (out_take) begin
      prev_level <= sample_level;
      prev_time  <= sample_time;
    end
  end

  `UBCR_ASSERT_NEXT(a_reset_no_out, clk, 1'b0, rst, !out_valid)

  `UBCR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_time) && $stable(sample_level) && $stable(last_of_run))

  `UBCR_ASSERT_SAME(a_level_toggles, clk, rst, out_take && mid_run, sample_level != prev_level)

  `UBCR_ASSERT_SAME(a_centre_step, clk, rst, out_take && mid_run, (sample_time == prev_time + {17'd0, period}))

  // Inputs seen only by the binding
  logic unused_ok;
  assign unused_ok = in_valid ^ in_ready ^ (^edge_time) ^ new_capture;

endmodule

bind uart_bit_clock_recovery_unit ubcr_checker u_ubcr_checker (.*);

`default_nettype wire
